>>> src/mme_pkg.sv
package mme_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = 4;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = 40;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

  function automatic logic [DIM_W-1:0] used_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> src/matrix_multiply_engine_top.sv
// matrix multiply engine, C = A * B on signed Q8.8 elements
// input stream: s_tuser carries op (0 load A, 1 load B, 2 start), s_tdata
// carries the row-major element index and the Q8.8 value
// load transfers are taken one per cycle whenever the block is idle and
// produce no result
// a start checks a_cols against b_rows (registers clamped to 1..8); on a
// mismatch the output state sends one result with status 1 and tlast high
// otherwise the product is sent in row-major order as signed Q24.16 values with
// row and column, tlast on the final element
// each product element takes one inner step per cycle through the single
// shared multiply-accumulate unit, then a drain of its read and multiply
// registers, then a load of the output register
// s_tready stays low from a start until its last result is in the output
// register; a stalled receiver holds the sequencer in its output state
// reset restores every dimension register to 1 and empties the output;
// element stores keep their contents and must be loaded before a start
module matrix_multiply_engine_top
  import mme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // elem_index, elem_value
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // product_value, out_row, out_col
  output logic [0:0]  m_tuser,   // status
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ISSUE   = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;
  localparam logic [1:0] ST_DELIVER = 2'd3;

  logic [1:0]        state;
  logic [DIM_W-1:0]  a_rows, a_cols, b_rows, b_cols;
  logic [DIM_W-1:0]  dim_m, dim_n, dim_q;
  logic [CNT_W-1:0]  row, col, kk;
  logic [IDX_W-1:0]  a_base, b_ptr;
  logic              drain_cnt;
  logic              err;

  logic [ELEM_W-1:0] a_mem [STORE_DEPTH];
  logic [ELEM_W-1:0] b_mem [STORE_DEPTH];
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  logic              in_xfer;
  logic [1:0]        op;
  logic [IDX_W-1:0]  elem_index;
  logic [ELEM_W-1:0] elem_value;
  logic [IDX_W-1:0]  a_addr;
  logic              out_free;
  logic              k_done, col_done, row_done;
  logic [DIM_W-1:0]  used_m, used_n, used_p, used_q;
  mac_ctl_t          ctl_issue, ctl_rd;
  logic signed [ACC_W-1:0] acc;

  assign op         = s_tuser;
  assign elem_index = s_tdata[IDX_W-1:0];
  assign elem_value = s_tdata[IDX_W+ELEM_W-1:IDX_W];
  assign s_tready   = (state == ST_IDLE);
  assign in_xfer    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;

  assign used_m = used_dim(a_rows);
  assign used_n = used_dim(a_cols);
  assign used_p = used_dim(b_rows);
  assign used_q = used_dim(b_cols);

  assign a_addr   = a_base + IDX_W'(kk);
  assign k_done   = ({1'b0, kk} == dim_n - DIM_W'(1));
  assign col_done = ({1'b0, col} == dim_q - DIM_W'(1));
  assign row_done = ({1'b0, row} == dim_m - DIM_W'(1));

  assign ctl_issue.valid = (state == ST_ISSUE);
  assign ctl_issue.first = (kk == '0);

  // element stores
  always_ff @(posedge clk) begin
    if (in_xfer && op == OP_LOAD_A) begin
      a_mem[elem_index] <= elem_value;
    end
    if (in_xfer && op == OP_LOAD_B) begin
      b_mem[elem_index] <= elem_value;
    end
    a_rdata <= a_mem[a_addr];
    b_rdata <= b_mem[b_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd <= '0;
    end else begin
      ctl_rd <= ctl_issue;
    end
  end

  mme_mac u_mac (
    .clk (clk),
    .ctl (ctl_rd),
    .a   (a_rdata),
    .b   (b_rdata),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_W'(1);
      a_cols <= DIM_W'(1);
      b_rows <= DIM_W'(1);
      b_cols <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROWS: a_rows <= cfg_wdata;
        REG_A_COLS: a_cols <= cfg_wdata;
        REG_B_ROWS: b_rows <= cfg_wdata;
        REG_B_COLS: b_cols <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      err       <= 1'b0;
      drain_cnt <= 1'b0;
    end else begin
      if (state == ST_DELIVER && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && op == OP_START) begin
            dim_m  <= used_m;
            dim_n  <= used_n;
            dim_q  <= used_q;
            row    <= '0;
            col    <= '0;
            kk     <= '0;
            a_base <= '0;
            b_ptr  <= '0;
            if (used_n != used_p) begin
              err   <= 1'b1;
              state <= ST_DELIVER;
            end else begin
              err   <= 1'b0;
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          kk    <= kk + CNT_W'(1);
          b_ptr <= b_ptr + IDX_W'(dim_q);
          if (k_done) begin
            drain_cnt <= 1'b0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            state <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (out_free) begin
            if (err) begin
              m_tdata <= '0;
              m_tuser <= 1'b1;
              m_tlast <= 1'b1;
              state   <= ST_IDLE;
            end else begin
              m_tdata <= {2'b00, col, row, acc};
              m_tuser <= 1'b0;
              m_tlast <= row_done && col_done;
              kk      <= '0;
              if (row_done && col_done) begin
                state <= ST_IDLE;
              end else begin
                state <= ST_ISSUE;
              end
              if (col_done) begin
                col    <= '0;
                b_ptr  <= '0;
                row    <= row + CNT_W'(1);
                a_base <= a_base + IDX_W'(dim_n);
              end else begin
                col   <= col + CNT_W'(1);
                b_ptr <= IDX_W'(col) + IDX_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/mme_mac.sv
module mme_mac
  import mme_pkg::*;
(
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [ELEM_W-1:0] a,
  input  logic signed [ELEM_W-1:0] b,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 ctl_d;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    prod  <= PROD_W'(a) * PROD_W'(b);
    ctl_d <= ctl;
    if (ctl_d.valid) begin
      if (ctl_d.first) begin
        acc <= prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

endmodule

>>> sim/matrix_multiply_engine_top_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_engine_top_tb;
  import mme_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int TARGET_ITEMS = 460;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  index;
    logic [15:0] value;
  } mm_item_t;

  typedef struct packed {
    logic [39:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        status;
    logic        last;
  } product_elem_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_wdata = '0;

  mm_item_t      pending_items[$];
  product_elem_t expected_products[$];

  // engine state as seen by the predictor
  logic signed [15:0] a_elems[STORE_DEPTH];
  logic signed [15:0] b_elems[STORE_DEPTH];
  logic [3:0]         dim_regs[4] = '{4'd1, 4'd1, 4'd1, 4'd1};

  // entries already loaded, tracked when items are queued
  bit a_loaded[STORE_DEPTH];
  bit b_loaded[STORE_DEPTH];

  int            stim_count = 0;
  int            mismatch_count = 0;
  int            results_seen = 0;
  int            burst_left = 8;
  int            gap_left = 0;
  int            hold_left = 0;
  int            next_hold_at = 40;
  logic [31:0]   rcv_cycle = '0;
  mm_item_t      cur_item;
  product_elem_t got, want;

  matrix_multiply_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int clamp_dim(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void predict_products(input mm_item_t item);
    int m, n, p, q;
    longint acc;
    product_elem_t r;
    case (item.op)
      OP_LOAD_A: a_elems[item.index] = item.value;
      OP_LOAD_B: b_elems[item.index] = item.value;
      OP_START: begin
        m = clamp_dim(dim_regs[REG_A_ROWS]);
        n = clamp_dim(dim_regs[REG_A_COLS]);
        p = clamp_dim(dim_regs[REG_B_ROWS]);
        q = clamp_dim(dim_regs[REG_B_COLS]);
        if (n != p) begin
          r = '{value: '0, row: '0, col: '0, status: 1'b1, last: 1'b1};
          expected_products.push_back(r);
        end else begin
          for (int i = 0; i < m; i++) begin
            for (int j = 0; j < q; j++) begin
              acc = 0;
              for (int k = 0; k < n; k++) begin
                acc += longint'(a_elems[i * n + k]) * longint'(b_elems[k * q + j]);
              end
              r.value  = acc[39:0];
              r.row    = i[2:0];
              r.col    = j[2:0];
              r.status = 1'b0;
              r.last   = (i == m - 1) && (j == q - 1);
              expected_products.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_product();
    got.value  = m_tdata[39:0];
    got.row    = m_tdata[42:40];
    got.col    = m_tdata[45:43];
    got.status = m_tuser[0];
    got.last   = m_tlast;
    results_seen++;
    if (expected_products.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%t unexpected result: value %h row %0d col %0d status %0d last %0d",
                 $realtime, got.value, got.row, got.col, got.status, got.last);
    end else begin
      want = expected_products.pop_front();
      if (got != want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%t result %0d: expected value %h row %0d col %0d status %0d last %0d",
                   $realtime, results_seen, want.value, want.row, want.col, want.status,
                   want.last);
          $display("  got value %h row %0d col %0d status %0d last %0d",
                   got.value, got.row, got.col, got.status, got.last);
        end
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_products(cur_item);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, cur_item.value, cur_item.index};
          s_tuser  <= cur_item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_product();
      rcv_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (m_tvalid && pending_items.size() != 0 &&
                   results_seen >= next_hold_at) begin
        // long hold-off while a start is in flight
        hold_left = 300;
        next_hold_at += 700;
        m_tready <= 1'b0;
      end else begin
        case (rcv_cycle[7:6])
          2'd0:    m_tready <= 1'b1;
          2'd1:    m_tready <= $urandom_range(0, 1);
          2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [5:0] idx,
                          input logic [15:0] val);
    mm_item_t item;
    item = '{op: op, index: idx, value: val};
    pending_items.push_back(item);
    if (op == OP_LOAD_A) a_loaded[idx] = 1'b1;
    if (op == OP_LOAD_B) b_loaded[idx] = 1'b1;
    if (op != OP_UNUSED) stim_count++;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // loads what the start needs if inner dimensions match (and a random share of the rest), then starts
  task automatic add_start(input int reload_pct);
    int m, n, p, q;
    m = clamp_dim(dim_regs[REG_A_ROWS]);
    n = clamp_dim(dim_regs[REG_A_COLS]);
    p = clamp_dim(dim_regs[REG_B_ROWS]);
    q = clamp_dim(dim_regs[REG_B_COLS]);
    if (n == p) begin
      for (int e = 0; e < m * n; e++)
        if (!a_loaded[e] || $urandom_range(0, 99) < reload_pct)
          add_item(OP_LOAD_A, e[5:0], rand_elem());
      for (int e = 0; e < n * q; e++)
        if (!b_loaded[e] || $urandom_range(0, 99) < reload_pct)
          add_item(OP_LOAD_B, e[5:0], rand_elem());
    end
    if ($urandom_range(0, 4) == 0) add_item(OP_UNUSED, 6'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0)
      add_item(($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B, 6'($urandom), rand_elem());
    add_item(OP_START, 6'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_products.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    dim_regs[idx] = val;
  endtask

  task automatic set_dims(input logic [3:0] ar, input logic [3:0] ac,
                          input logic [3:0] br, input logic [3:0] bc);
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_A_COLS, ac);
    write_reg(REG_B_ROWS, br);
    write_reg(REG_B_COLS, bc);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [3:0] ar, ac, br, bc;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 1x1 after reset: value extremes, unused op, top store entry
    add_item(OP_LOAD_A, 6'd0, 16'h8000);
    add_item(OP_LOAD_B, 6'd0, 16'h8000);
    add_item(OP_START, 6'd0, 16'h0000);
    add_item(OP_LOAD_A, 6'd0, 16'h7fff);
    add_item(OP_START, 6'd63, 16'hffff);
    add_item(OP_UNUSED, 6'h2a, 16'h5555);
    add_item(OP_LOAD_B, 6'd0, 16'h7fff);
    add_item(OP_START, 6'h15, 16'haaaa);
    add_item(OP_LOAD_A, 6'd63, 16'hffff);
    add_item(OP_LOAD_B, 6'd63, 16'h0001);
    wait_idle();

    // inner dimension mismatch, back to back
    set_dims(4'd0, 4'd2, 4'd3, 4'd0);
    add_start(0);
    add_item(OP_START, 6'd0, 16'h0000);
    wait_idle();

    // zero registers act as one
    set_dims(4'd0, 4'd0, 4'd0, 4'd0);
    add_item(OP_LOAD_A, 6'd0, 16'hffff);
    add_item(OP_LOAD_B, 6'd0, 16'hffff);
    add_item(OP_START, 6'd0, 16'h0000);
    wait_idle();

    set_dims(4'd2, 4'd3, 4'd3, 4'd2);
    add_start(100);

    while (stim_count < TARGET_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: begin
          // above range, clamped to full size
          ar = 4'($urandom_range(9, 15));
          ac = 4'($urandom_range(8, 15));
          br = 4'($urandom_range(8, 15));
          bc = 4'($urandom_range(9, 15));
        end
        1: begin
          ar = 4'd8; ac = 4'd8; br = 4'd8; bc = 4'd8;
        end
        2: begin
          ar = 4'($urandom_range(0, 15));
          ac = 4'($urandom_range(1, 8));
          do br = 4'($urandom_range(1, 8)); while (br == ac);
          bc = 4'($urandom_range(0, 15));
        end
        3: begin
          ar = 4'($urandom_range(0, 1));
          ac = 4'd0;
          br = 4'd1;
          bc = 4'($urandom_range(0, 1));
        end
        default: begin
          ar = 4'($urandom_range(1, 4));
          ac = 4'($urandom_range(1, 4));
          br = ac;
          bc = 4'($urandom_range(1, 4));
        end
      endcase
      set_dims(ar, ac, br, bc);
      repeat ($urandom_range(1, 3)) add_start($urandom_range(10, 100));
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && expected_products.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
